// ===== hw/rtl/jtag_pkg.sv =====
`timescale 1ns / 1ps
package jtag_pkg;

  localparam int IR_BITS_DEFAULT        = 10;
  localparam int MAX_IDLE_TICKS_DEFAULT = 32;

  localparam int TICK_W      = 6;
  localparam int CAP_W       = 10;
  localparam int MAX_TICKS   = 32;
  localparam int RESET_TICKS = 5;
  localparam int IR_PATH_LEN = 5;
  localparam int IR_BASE     = RESET_TICKS + IR_PATH_LEN;
  localparam int DR_MAX      = 8;

  localparam logic [IR_PATH_LEN-1:0] IR_PATH = 5'b00110;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;

  localparam logic [2:0] OP_RESET = 3'd0;
  localparam logic [2:0] OP_PATH  = 3'd1;
  localparam logic [2:0] OP_IR    = 3'd2;
  localparam logic [2:0] OP_DR    = 3'd3;
  localparam logic [2:0] OP_IDLE  = 3'd4;

  typedef struct packed {
    logic [2:0]  op;
    logic [5:0]  count;
    logic [9:0]  pattern;
    logic        final_tms;
    logic [31:0] tdo_levels;
  } in_t;

  typedef struct packed {
    logic             tms_out;
    logic             tdi_out;
    logic             last_tick;
    logic [CAP_W-1:0] captured;
  } out_t;

  typedef struct packed {
    logic [TICK_W-1:0]    ticks;
    logic [MAX_TICKS-1:0] tms_bits;
    logic [MAX_TICKS-1:0] tdi_bits;
    logic [CAP_W-1:0]     cap;
  } cmd_t;

endpackage

// ===== hw/rtl/jtag_front.sv =====
`timescale 1ns / 1ps
module jtag_front import jtag_pkg::*; #(
  parameter int IR_BITS        = IR_BITS_DEFAULT,
  parameter int MAX_IDLE_TICKS = MAX_IDLE_TICKS_DEFAULT
) (
  input  logic in_valid_i,
  input  in_t  in_payload_i,
  output logic in_stall_o,
  input  logic q_full_i,
  output logic push_o,
  output cmd_t cmd_o
);

  localparam int IR_LEN   = (IR_BITS > MAX_TICKS - IR_BASE) ? (MAX_TICKS - IR_BASE) : IR_BITS;
  localparam int IR_TICKS = IR_BASE + IR_LEN;
  localparam logic [CAP_W-1:0] IR_MASK =
    (IR_LEN >= CAP_W) ? {CAP_W{1'b1}} : CAP_W'((32'h1 << IR_LEN) - 32'h1);
  localparam logic [MAX_TICKS-1:0] IR_TMS =
    MAX_TICKS'((32'h1 << RESET_TICKS) - 32'h1) | (MAX_TICKS'(IR_PATH) << RESET_TICKS)
    | (MAX_TICKS'(1) << (IR_TICKS - 1));
  localparam logic [TICK_W-1:0] IDLE_MAX = TICK_W'(MAX_IDLE_TICKS);
  localparam logic [TICK_W-1:0] DR_SAT   = TICK_W'(DR_MAX);

  logic [TICK_W-1:0] n_short;
  logic [TICK_W-1:0] n_idle;
  logic [7:0]        mask8;
  logic              known;

  always_comb begin
    if (in_payload_i.count == '0) begin
      n_short = TICK_W'(1);
    end else if (in_payload_i.count > DR_SAT) begin
      n_short = DR_SAT;
    end else begin
      n_short = in_payload_i.count;
    end
    if (in_payload_i.count == '0) begin
      n_idle = TICK_W'(1);
    end else if (in_payload_i.count > IDLE_MAX) begin
      n_idle = IDLE_MAX;
    end else begin
      n_idle = in_payload_i.count;
    end
    mask8 = 8'((9'h1 << n_short[3:0]) - 9'h1);
  end

  always_comb begin
    cmd_o = '0;
    known = 1'b1;
    case (in_payload_i.op)
      OP_RESET: begin
        cmd_o.ticks    = TICK_W'(RESET_TICKS);
        cmd_o.tms_bits = MAX_TICKS'((32'h1 << RESET_TICKS) - 32'h1);
      end
      OP_PATH: begin
        cmd_o.ticks    = n_short;
        cmd_o.tms_bits = MAX_TICKS'(in_payload_i.pattern[7:0]);
      end
      OP_IR: begin
        cmd_o.ticks    = TICK_W'(IR_TICKS);
        cmd_o.tms_bits = IR_TMS;
        cmd_o.tdi_bits = MAX_TICKS'(in_payload_i.pattern & IR_MASK) << IR_BASE;
        cmd_o.cap      = in_payload_i.tdo_levels[IR_BASE +: CAP_W] & IR_MASK;
      end
      OP_DR: begin
        cmd_o.ticks    = n_short;
        cmd_o.tms_bits = MAX_TICKS'(in_payload_i.final_tms) << (n_short - TICK_W'(1));
        cmd_o.tdi_bits = MAX_TICKS'(in_payload_i.pattern[7:0] & mask8);
        cmd_o.cap      = CAP_W'(in_payload_i.tdo_levels[7:0] & mask8);
      end
      OP_IDLE: begin
        cmd_o.ticks    = n_idle;
        cmd_o.tms_bits = {MAX_TICKS{in_payload_i.final_tms}};
      end
      default: begin
        known = 1'b0;
      end
    endcase
  end

  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i && known;

endmodule

// ===== hw/rtl/jtag_queue.sv =====
`timescale 1ns / 1ps
module jtag_queue import jtag_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_data_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output cmd_t pop_data_o
);

  cmd_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QPTR_W:0]   count_q, count_d;

  assign full_o     = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty_o    = (count_q == '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + QPTR_W'(1) : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + QPTR_W'(1) : rd_ptr_q;
    count_d  = count_q + (QPTR_W+1)'(push_i) - (QPTR_W+1)'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== hw/rtl/jtag_back.sv =====
`timescale 1ns / 1ps
module jtag_back import jtag_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic q_empty_i,
  input  cmd_t q_data_i,
  output logic pop_o,
  output logic busy_o,
  output logic out_valid_o,
  output out_t out_payload_o,
  input  logic out_stall_i
);

  logic                 busy_q, busy_d;
  logic [TICK_W-1:0]    left_q, left_d;
  logic [MAX_TICKS-1:0] tms_q, tms_d;
  logic [MAX_TICKS-1:0] tdi_q, tdi_d;
  logic [CAP_W-1:0]     cap_q, cap_d;
  logic                 out_valid_q, out_valid_d;
  out_t                 out_q, out_d;
  logic                 emit;
  logic                 last;

  assign pop_o  = !busy_q && !q_empty_i;
  assign emit   = busy_q && (!out_valid_q || !out_stall_i);
  assign last   = (left_q == TICK_W'(1));
  assign busy_o = busy_q;

  always_comb begin
    busy_d      = busy_q;
    left_d      = left_q;
    tms_d       = tms_q;
    tdi_d       = tdi_q;
    cap_d       = cap_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (pop_o) begin
      busy_d = 1'b1;
      left_d = q_data_i.ticks;
      tms_d  = q_data_i.tms_bits;
      tdi_d  = q_data_i.tdi_bits;
      cap_d  = q_data_i.cap;
    end else if (emit) begin
      out_valid_d     = 1'b1;
      out_d.tms_out   = tms_q[0];
      out_d.tdi_out   = tdi_q[0];
      out_d.last_tick = last;
      out_d.captured  = last ? cap_q : '0;
      tms_d           = tms_q >> 1;
      tdi_d           = tdi_q >> 1;
      left_d          = left_q - TICK_W'(1);
      busy_d          = !last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    left_q <= left_d;
    tms_q  <= tms_d;
    tdi_q  <= tdi_d;
    cap_q  <= cap_d;
    out_q  <= out_d;
  end

  assign out_valid_o   = out_valid_q;
  assign out_payload_o = out_q;

endmodule

// ===== hw/rtl/jtag_tap_command_shifter.sv =====
`timescale 1ns / 1ps
// JTAG TAP master command shifter.
// Input channel: one command per transfer (reset, TMS path, IR shift, DR shift,
// idle ticks) together with the TDO levels seen on its ticks. Output channel:
// one transfer per TCK tick with the TMS and TDI levels; the final tick of a
// command has last_tick set and carries the captured TDO data bits.
// A decoder turns each command into TMS/TDI tick vectors and a tick count and
// writes them into a two-entry queue; a shifter plays them out one tick per
// cycle into an output register while the receiver does not stall.
// A command passes from the queue into the shifter, and each tick from the
// shifter into the output register; the shifter takes a command from the queue
// only while idle, so it loads the next command after the last tick of this one.
// Commands with an undefined op are accepted and produce no ticks.
// When the receiver stalls, the output register holds its tick and the shifter
// waits; the input stalls only while the queue is full.
// Reset empties the queue and the output register; no clearing pass is needed.
module jtag_tap_command_shifter import jtag_pkg::*; #(
  parameter int IR_BITS        = IR_BITS_DEFAULT,
  parameter int MAX_IDLE_TICKS = MAX_IDLE_TICKS_DEFAULT
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  in_t  in_payload_i,
  output logic in_stall_o,
  output logic out_valid_o,
  output out_t out_payload_o,
  input  logic out_stall_i
);

  logic push;
  cmd_t push_cmd;
  logic q_full;
  logic q_empty;
  logic pop;
  cmd_t pop_cmd;
  logic busy;

  jtag_front #(
    .IR_BITS        (IR_BITS),
    .MAX_IDLE_TICKS (MAX_IDLE_TICKS)
  ) u_front (
    .in_valid_i   (in_valid_i),
    .in_payload_i (in_payload_i),
    .in_stall_o   (in_stall_o),
    .q_full_i     (q_full),
    .push_o       (push),
    .cmd_o        (push_cmd)
  );

  jtag_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_cmd),
    .full_o      (q_full),
    .pop_i       (pop),
    .empty_o     (q_empty),
    .pop_data_o  (pop_cmd)
  );

  jtag_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_empty_i     (q_empty),
    .q_data_i      (pop_cmd),
    .pop_o         (pop),
    .busy_o        (busy),
    .out_valid_o   (out_valid_o),
    .out_payload_o (out_payload_o),
    .out_stall_i   (out_stall_i)
  );

  a_capture_only_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_payload_o.last_tick |-> out_payload_o.captured == '0)
    else $error("captured data on a tick that is not the last");

  a_hold_when_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_payload_o))
    else $error("stalled tick dropped or changed");

  a_known_op_queued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (in_payload_i.op <= OP_IDLE) |=> !q_empty || busy)
    else $error("accepted command lost between decoder and shifter");

  a_pop_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !busy && !q_empty)
    else $error("queue popped while shifter busy or queue empty");

endmodule
